/* sv/minmax_feature_normalizer_defines.svh */
// assertion macros shared by the normaliser modules
`ifndef MINMAX_FEATURE_NORMALIZER_DEFINES_SVH
`define MINMAX_FEATURE_NORMALIZER_DEFINES_SVH

// same-cycle implication, held off while reset is low
`define MMFN_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("mmfn assertion failed");

// next-cycle implication, held off while reset is low
`define MMFN_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("mmfn assertion failed");

`endif

/* sv/mmfn_pkg.sv */
package mmfn_pkg;

    localparam int NUM_FEATURES_DEF = 4;
    localparam int MAX_ROWS_DEF     = 256;

    localparam int CMD_W    = 2;
    localparam int SAMPLE_W = 16;
    localparam int NORM_W   = 16;
    localparam int FIDX_W   = 2;

    // one quotient bit per divider step
    localparam int DIV_STEPS = NORM_W;

    localparam logic [CMD_W-1:0] CMD_LOAD = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ = 2'd1;
    localparam logic [CMD_W-1:0] CMD_NEW  = 2'd2;

    typedef struct packed {
        logic load_en;
        logic read_en;
        logic clear_en;
        logic prep_en;
        logic div_en;
        logic out_load;
    } ctrl_cmd_t;

    typedef struct packed {
        logic rd_empty;
        logic out_free;
    } dp_status_t;

endpackage

/* sv/mmfn_ram.sv */
module mmfn_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/mmfn_ctrl.sv */
module mmfn_ctrl
    import mmfn_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [CMD_W-1:0] s_cmd,
    output logic             s_ready,
    input  dp_status_t       status,
    output ctrl_cmd_t        cmd
);

`include "minmax_feature_normalizer_defines.svh"

    localparam int CNT_W = $clog2(DIV_STEPS);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             accept;
    logic             cnt_last;

    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign cnt_last = (cnt_reg == CNT_W'(DIV_STEPS - 1));

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_cmd)
                        CMD_LOAD: cmd.load_en = 1'b1;
                        CMD_NEW:  cmd.clear_en = 1'b1;
                        CMD_READ: begin
                            cmd.read_en = 1'b1;
                            state_next  = status.rd_empty ? ST_EMIT : ST_PREP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_PREP: begin
                cmd.prep_en = 1'b1;
                cnt_next    = '0;
                state_next  = ST_DIV;
            end
            ST_DIV: begin
                cmd.div_en = 1'b1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_last) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    `MMFN_ASSERT_NEXT(a_read_to_prep, aclk, aresetn, accept && s_cmd == CMD_READ && !status.rd_empty, state_reg == ST_PREP)
    `MMFN_ASSERT_NEXT(a_div_to_emit, aclk, aresetn, state_reg == ST_DIV && cnt_last, state_reg == ST_EMIT)
    `MMFN_ASSERT_NEXT(a_emit_to_idle, aclk, aresetn, state_reg == ST_EMIT && status.out_free, state_reg == ST_IDLE)

endmodule

/* sv/mmfn_dp.sv */
module mmfn_dp
    import mmfn_pkg::*;
#(
    parameter int NUM_FEATURES = NUM_FEATURES_DEF,
    parameter int MAX_ROWS     = MAX_ROWS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  ctrl_cmd_t                  cmd,
    output dp_status_t                 status,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [NORM_W-1:0]          m_norm_value,
    output logic [FIDX_W-1:0]          m_feature_index,
    output logic                       m_last,
    output logic                       m_status
);

`include "minmax_feature_normalizer_defines.svh"

    localparam int DEPTH  = NUM_FEATURES * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PTR_W  = $clog2(DEPTH + 1);
    localparam int COL_W  = (NUM_FEATURES > 1) ? $clog2(NUM_FEATURES) : 1;

    // pointers and row bookkeeping
    logic [PTR_W-1:0] load_ptr_reg;
    logic [COL_W-1:0] load_col_reg;
    logic [PTR_W-1:0] total_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [COL_W-1:0] rd_col_reg;

    logic signed [SAMPLE_W-1:0] row_buf_reg [NUM_FEATURES];
    logic signed [SAMPLE_W-1:0] min_reg     [NUM_FEATURES];
    logic signed [SAMPLE_W-1:0] max_reg     [NUM_FEATURES];

    // per-read holding registers
    logic [COL_W-1:0]  col_hold_reg;
    logic              last_hold_reg;
    logic              err_hold_reg;
    logic              zero_hold_reg;
    logic              sat_hold_reg;
    logic [NORM_W-1:0] rem_reg;
    logic [NORM_W-1:0] range_reg;
    logic [NORM_W-1:0] quot_reg;

    logic                m_valid_reg;
    logic [NORM_W-1:0]   norm_reg;
    logic [FIDX_W-1:0]   fidx_reg;
    logic                last_reg;
    logic                status_reg;

    logic                       store_room;
    logic                       row_close;
    logic [SAMPLE_W-1:0]        ram_rd_data;
    logic signed [SAMPLE_W:0]   diff_w;
    logic signed [SAMPLE_W:0]   range_w;
    logic [NORM_W:0]            dbl_w;
    logic [NORM_W:0]            sub_w;
    logic                       ge_w;

    assign store_room = (load_ptr_reg != PTR_W'(DEPTH));
    assign row_close  = (load_col_reg == COL_W'(NUM_FEATURES - 1));

    assign status.rd_empty = (rd_ptr_reg >= total_reg);
    assign status.out_free = !m_valid_reg || m_ready;

    mmfn_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (cmd.load_en && store_room),
        .wr_addr (load_ptr_reg[ADDR_W-1:0]),
        .wr_data (s_sample_value),
        .rd_en   (cmd.read_en),
        .rd_addr (rd_ptr_reg[ADDR_W-1:0]),
        .rd_data (ram_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            load_ptr_reg <= '0;
            load_col_reg <= '0;
            total_reg    <= '0;
            rd_ptr_reg   <= '0;
            rd_col_reg   <= '0;
        end else if (cmd.clear_en) begin
            load_ptr_reg <= '0;
            load_col_reg <= '0;
            total_reg    <= '0;
            rd_ptr_reg   <= '0;
            rd_col_reg   <= '0;
        end else begin
            if (cmd.load_en && store_room) begin
                load_ptr_reg <= load_ptr_reg + 1'b1;
                if (row_close) begin
                    load_col_reg <= '0;
                    total_reg    <= total_reg + PTR_W'(NUM_FEATURES);
                end else begin
                    load_col_reg <= load_col_reg + 1'b1;
                end
            end
            if (cmd.read_en && !status.rd_empty) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
                rd_col_reg <= (rd_col_reg == COL_W'(NUM_FEATURES - 1)) ? '0
                                                                       : rd_col_reg + 1'b1;
            end
        end
    end

    // row buffer, filled on each load, and per-feature range, updated as a row closes
    always_ff @(posedge aclk) begin
        if (cmd.load_en && store_room) begin
            row_buf_reg[load_col_reg] <= s_sample_value;
            if (row_close) begin
                for (int f = 0; f < NUM_FEATURES; f++) begin
                    logic signed [SAMPLE_W-1:0] v;
                    v = (f == NUM_FEATURES - 1) ? s_sample_value : row_buf_reg[f];
                    if (total_reg == '0) begin
                        min_reg[f] <= v;
                        max_reg[f] <= v;
                    end else begin
                        if (v < min_reg[f]) min_reg[f] <= v;
                        if (v > max_reg[f]) max_reg[f] <= v;
                    end
                end
            end
        end
    end

    // operand set-up in the cycle after the store read
    assign diff_w  = $signed({ram_rd_data[SAMPLE_W-1], ram_rd_data})
                   - $signed({min_reg[col_hold_reg][SAMPLE_W-1], min_reg[col_hold_reg]});
    assign range_w = $signed({max_reg[col_hold_reg][SAMPLE_W-1], max_reg[col_hold_reg]})
                   - $signed({min_reg[col_hold_reg][SAMPLE_W-1], min_reg[col_hold_reg]});

    // restoring divider step; the remainder stays below the range unless the result is zeroed or saturated
    assign dbl_w = {rem_reg, 1'b0};
    assign sub_w = dbl_w - {1'b0, range_reg};
    assign ge_w  = (dbl_w >= {1'b0, range_reg});

    always_ff @(posedge aclk) begin
        if (cmd.read_en) begin
            col_hold_reg  <= rd_col_reg;
            last_hold_reg <= (PTR_W'(rd_ptr_reg + 1'b1) == total_reg);
            err_hold_reg  <= status.rd_empty;
        end
        if (cmd.prep_en) begin
            zero_hold_reg <= (range_w <= 0) || (diff_w <= 0);
            sat_hold_reg  <= (diff_w >= range_w);
            rem_reg       <= diff_w[NORM_W-1:0];
            range_reg     <= range_w[NORM_W-1:0];
            quot_reg      <= '0;
        end
        if (cmd.div_en) begin
            rem_reg  <= ge_w ? sub_w[NORM_W-1:0] : dbl_w[NORM_W-1:0];
            quot_reg <= {quot_reg[NORM_W-2:0], ge_w};
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (err_hold_reg) begin
                norm_reg   <= '0;
                fidx_reg   <= '0;
                last_reg   <= 1'b0;
                status_reg <= 1'b1;
            end else begin
                norm_reg   <= zero_hold_reg ? '0 : (sat_hold_reg ? '1 : quot_reg);
                fidx_reg   <= FIDX_W'(col_hold_reg);
                last_reg   <= last_hold_reg;
                status_reg <= 1'b0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_norm_value    = norm_reg;
    assign m_feature_index = fidx_reg;
    assign m_last          = last_reg;
    assign m_status        = status_reg;

    `MMFN_ASSERT_NEXT(a_rd_ptr_step, aclk, aresetn, cmd.read_en && !status.rd_empty && !cmd.clear_en, rd_ptr_reg == $past(rd_ptr_reg) + 1'b1)
    `MMFN_ASSERT_NOW(a_rd_within_total, aclk, aresetn, 1'b1, rd_ptr_reg <= total_reg)
    `MMFN_ASSERT_NEXT(a_out_loaded, aclk, aresetn, cmd.out_load, m_valid_reg)

endmodule

/* sv/minmax_feature_normalizer.sv */
// min-max feature normaliser. beats on s_ carry a command: load stores one
// signed q8.8 element (row-major, NUM_FEATURES to a row), new set rewinds the
// load, row and read pointers, read returns one beat on m_ holding the next
// stored element of the complete rows as (x - min) / (max - min) in unsigned
// q0.16, truncated, saturated at 65535, zero when the range is empty. a read
// with nothing left returns status 1 and zero fields; loads past capacity are
// dropped; command 3 is ignored. load and new set complete on the accepting
// edge. a read runs in order: the store is read on the accepting edge, the
// set-up state forms x - min and max - min, the divide state runs the
// restoring divider (one quotient bit a cycle) and the result state writes
// the result once the output register is free. no new beat is taken until
// that write, so one read is finished before the next is taken. a status-1
// read goes from acceptance straight to the result write. the result waits
// in the output register, so loads and new-set beats are taken while it is
// still unclaimed. the sample store needs no clearing pass after reset and
// a read only ever reaches elements loaded in the current set
module minmax_feature_normalizer
    import mmfn_pkg::*;
#(
    parameter int NUM_FEATURES = NUM_FEATURES_DEF,
    parameter int MAX_ROWS     = MAX_ROWS_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // command channel
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [CMD_W-1:0]           s_cmd,
    input  logic signed [SAMPLE_W-1:0] s_sample_value,
    // result channel
    output logic                       m_valid,
    input  logic                       m_ready,
    output logic [NORM_W-1:0]          m_norm_value,
    output logic [FIDX_W-1:0]          m_feature_index,
    output logic                       m_last,
    output logic                       m_status
);

    ctrl_cmd_t  ctrl_cmd;
    dp_status_t dp_status;

    // sequencer: idle, operand set-up, divide, result write
    mmfn_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_cmd   (s_cmd),
        .s_ready (s_ready),
        .status  (dp_status),
        .cmd     (ctrl_cmd)
    );

    // store, pointers, per-feature range, divider and output register
    mmfn_dp #(
        .NUM_FEATURES (NUM_FEATURES),
        .MAX_ROWS     (MAX_ROWS)
    ) u_dp (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cmd             (ctrl_cmd),
        .status          (dp_status),
        .s_sample_value  (s_sample_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_norm_value    (m_norm_value),
        .m_feature_index (m_feature_index),
        .m_last          (m_last),
        .m_status        (m_status)
    );

endmodule

/* sim/testbench.sv */
`timescale 1ns / 100ps

module testbench
    import mmfn_pkg::*;
();

    localparam int NF           = NUM_FEATURES_DEF;
    localparam int ROWS         = MAX_ROWS_DEF;
    localparam int STORE_DEPTH  = NF * ROWS;
    localparam int ITEM_TARGET  = 1650;
    localparam int LIMIT_CYCLES = 600000;
    localparam int HOLD_CYCLES  = 400;
    // settle time after the last beat, longer than a full read
    localparam int TAIL_CYCLES  = 40;

    // command 3 is not decoded by the block and must give no beat back
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    // one beat on the result channel
    typedef struct packed {
        logic [NORM_W-1:0] norm;
        logic [FIDX_W-1:0] fidx;
        logic              is_last;
        logic              status;
    } norm_beat_t;

    // ------------------------------------------------------------------
    // scoreboard: mirrors the sample store, the per-feature limits and the
    // three pointers, and keeps the normalised beats still owed by the block
    // ------------------------------------------------------------------
    class norm_scoreboard;
        logic signed [SAMPLE_W-1:0] samples [STORE_DEPTH];
        logic signed [SAMPLE_W-1:0] col_min [NF];
        logic signed [SAMPLE_W-1:0] col_max [NF];
        int unsigned                load_ptr;
        int unsigned                rows_done;
        int unsigned                read_ptr;
        norm_beat_t                 pending_norm [$];
        int                         faults;

        function new();
            foreach (col_min[f]) begin
                col_min[f] = '0;
                col_max[f] = '0;
            end
            load_ptr  = 0;
            rows_done = 0;
            read_ptr  = 0;
            faults    = 0;
        endfunction

        // fold a freshly completed row into the limits; the first row sets them
        function void close_row();
            int unsigned base;
            base = rows_done * NF;
            for (int f = 0; f < NF; f++) begin
                if (rows_done == 0) begin
                    col_min[f] = samples[base + f];
                    col_max[f] = samples[base + f];
                end else begin
                    if (samples[base + f] < col_min[f]) col_min[f] = samples[base + f];
                    if (samples[base + f] > col_max[f]) col_max[f] = samples[base + f];
                end
            end
            rows_done++;
        endfunction

        // (x-min)*65536/(max-min) truncated, clipped to 16 bits; 0 if a term<=0
        function logic [NORM_W-1:0] scaled_value(logic signed [SAMPLE_W-1:0] x, int f);
            int     lo;
            int     span;
            int     diff;
            longint q;
            lo   = col_min[f];
            span = int'(col_max[f]) - lo;
            diff = int'(x) - lo;
            if (span <= 0 || diff <= 0) return '0;
            q = (longint'(diff) << 16) / span;
            if (q > 65535) q = 65535;
            return q[NORM_W-1:0];
        endfunction

        function int unsigned unread();
            if (rows_done * NF > read_ptr) return rows_done * NF - read_ptr;
            return 0;
        endfunction

        function int pending();
            return pending_norm.size();
        endfunction

        // called for every beat the block accepts on the command channel
        function void note_beat(logic [CMD_W-1:0] cmd, logic signed [SAMPLE_W-1:0] val);
            norm_beat_t  want;
            int unsigned total;
            int          f;
            case (cmd)
                CMD_LOAD: begin
                    if (load_ptr < STORE_DEPTH) begin
                        samples[load_ptr] = val;
                        load_ptr++;
                        if (load_ptr % NF == 0) close_row();
                    end
                end
                CMD_READ: begin
                    total = rows_done * NF;
                    want  = '0;
                    if (read_ptr >= total || read_ptr >= STORE_DEPTH) begin
                        want.status = 1'b1;
                    end else begin
                        f            = read_ptr % NF;
                        want.norm    = scaled_value(samples[read_ptr], f);
                        want.fidx    = FIDX_W'(f);
                        want.is_last = (read_ptr + 1 == total);
                        read_ptr++;
                    end
                    pending_norm.push_back(want);
                end
                CMD_NEW: begin
                    load_ptr  = 0;
                    rows_done = 0;
                    read_ptr  = 0;
                end
                default: ;
            endcase
        endfunction

        // called for every beat the block hands over on the result channel
        function void check_result(norm_beat_t got);
            norm_beat_t want;
            if (pending_norm.size() == 0) begin
                faults++;
                if (faults <= 10)
                    $display("unexpected result beat: norm=%0d idx=%0d last=%0b status=%0b",
                             got.norm, got.fidx, got.is_last, got.status);
                return;
            end
            want = pending_norm.pop_front();
            if (got.norm !== want.norm || got.fidx !== want.fidx ||
                got.is_last !== want.is_last || got.status !== want.status) begin
                faults++;
                if (faults <= 10)
                    $display("result mismatch: expected norm=%0d idx=%0d last=%0b status=%0b, %s",
                             want.norm, want.fidx, want.is_last, want.status,
                             $sformatf("got norm=%0d idx=%0d last=%0b status=%0b",
                                       got.norm, got.fidx, got.is_last, got.status));
            end
        endfunction

        function bit clean();
            return faults == 0 && pending_norm.size() == 0;
        endfunction
    endclass

    // ------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------
    logic                       aclk;
    logic                       aresetn;
    logic                       s_valid;
    logic                       s_ready;
    logic [CMD_W-1:0]           s_cmd;
    logic signed [SAMPLE_W-1:0] s_sample_value;
    logic                       m_valid;
    logic                       m_ready;
    logic [NORM_W-1:0]          m_norm_value;
    logic [FIDX_W-1:0]          m_feature_index;
    logic                       m_last;
    logic                       m_status;

    minmax_feature_normalizer #(
        .NUM_FEATURES (NF),
        .MAX_ROWS     (ROWS)
    ) dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_cmd           (s_cmd),
        .s_sample_value  (s_sample_value),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_norm_value    (m_norm_value),
        .m_feature_index (m_feature_index),
        .m_last          (m_last),
        .m_status        (m_status)
    );

    norm_scoreboard board;

    int  beats_taken  = 0;  // accepted beats other than the unused command
    int  burst_left   = 0;  // beats left before the sender takes a gap
    bit  steady       = 0;  // no sender gaps at all in this stretch
    int  hold_request = 0;  // long receiver hold-off, picked up by the receiver

    // values for the zero-range and narrow-range row styles
    logic [SAMPLE_W-1:0] const_val [NF];
    logic [NF-1:0]       const_mask;
    logic [SAMPLE_W-1:0] centre;

    // ------------------------------------------------------------------
    // clock, watchdog
    // ------------------------------------------------------------------
    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // a correct run is far shorter; this only catches a hung handshake
    initial begin
        repeat (LIMIT_CYCLES) @(posedge aclk);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // ------------------------------------------------------------------
    // receiver: its own stall pattern, cycling through always-ready, coin
    // toss, mostly-stalled and a fixed rhythm, plus the long hold-off when
    // asked for (counted here, in this process)
    // ------------------------------------------------------------------
    initial begin
        int hold_left;
        int cyc;
        hold_left = 0;
        cyc       = 0;
        m_ready   = 1'b0;
        forever begin
            @(negedge aclk);
            cyc++;
            // request is set at a rising edge, so reading it here is race free
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else begin
                case ((cyc / 200) % 4)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 1) == 1);
                    2:       m_ready <= ($urandom_range(0, 3) == 0);
                    default: m_ready <= ((cyc % 7) < 4);
                endcase
            end
        end
    end

    // result monitor: outputs are sampled at the rising edge
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            board.check_result('{m_norm_value, m_feature_index, m_last, m_status});
    end

    // ------------------------------------------------------------------
    // sender tasks
    // ------------------------------------------------------------------

    // present one beat at the falling edge and hold it until accepted
    task automatic send_beat(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] val);
        @(negedge aclk);
        s_cmd          <= cmd;
        s_sample_value <= val;
        s_valid        <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        board.note_beat(cmd, val);
        if (cmd != CMD_UNUSED) beats_taken++;
    endtask

    task automatic gap(int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
    endtask

    // one beat plus the burst / gap shaping of the sender
    task automatic offer(logic [CMD_W-1:0] cmd, logic [SAMPLE_W-1:0] val);
        send_beat(cmd, val);
        if (!steady) begin
            if (burst_left == 0) begin
                gap($urandom_range(1, 10));
                burst_left = $urandom_range(1, 16);
            end else begin
                burst_left--;
            end
        end
    endtask

    // stop offering and wait until every owed result beat has come back
    task automatic drain();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (board.pending() != 0) @(negedge aclk);
    endtask

    // element values: full random, field extremes, constant columns for a
    // zero range, or a narrow band around a centre
    function automatic logic [SAMPLE_W-1:0] gen_value(int style, int f);
        case (style)
            0: return SAMPLE_W'($urandom);
            1: begin
                case ($urandom_range(0, 4))
                    0:       return 16'h8000;
                    1:       return 16'h7FFF;
                    2:       return 16'h0000;
                    3:       return 16'hFFFF;
                    default: return 16'h0001;
                endcase
            end
            2: return const_mask[f] ? const_val[f] : SAMPLE_W'($urandom);
            default: return centre + SAMPLE_W'($urandom_range(0, 64)) - 16'd32;
        endcase
    endfunction

    task automatic pick_row_shape();
        foreach (const_val[f]) const_val[f] = SAMPLE_W'($urandom);
        const_mask = NF'($urandom);
        centre     = SAMPLE_W'($urandom);
    endtask

    // load whole rows, with reads and the odd unused command mixed in
    task automatic load_rows(int nrows, int style, int read_pct);
        for (int r = 0; r < nrows; r++) begin
            for (int f = 0; f < NF; f++) begin
                offer(CMD_LOAD, gen_value(style, f));
                if ($urandom_range(1, 100) <= read_pct) offer(CMD_READ, SAMPLE_W'($urandom));
                if ($urandom_range(0, 40) == 0) offer(CMD_UNUSED, SAMPLE_W'($urandom));
            end
        end
    endtask

    task automatic read_out(int n);
        repeat (n) offer(CMD_READ, SAMPLE_W'($urandom));
    endtask

    // unstructured traffic: any command, any value
    task automatic noise_beats(int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(0, 99);
            if (pick < 50)      offer(CMD_LOAD, SAMPLE_W'($urandom));
            else if (pick < 85) offer(CMD_READ, SAMPLE_W'($urandom));
            else if (pick < 90) offer(CMD_NEW, SAMPLE_W'($urandom));
            else                offer(CMD_UNUSED, SAMPLE_W'($urandom));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int kind;
        board          = new();
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_cmd          = CMD_LOAD;
        s_sample_value = '0;
        const_mask     = '0;
        centre         = '0;
        foreach (const_val[f]) const_val[f] = '0;
        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        // --- directed part, sender without gaps ---
        steady = 1;
        // read straight after reset: nothing there yet
        offer(CMD_READ, 16'h0000);
        // unused command gives nothing back
        offer(CMD_UNUSED, 16'h1234);
        // two rows with the field extremes; column 2 stays at zero (empty range)
        offer(CMD_LOAD, 16'h7FFF);
        offer(CMD_LOAD, 16'h8000);
        offer(CMD_LOAD, 16'h0000);
        offer(CMD_LOAD, 16'h0100);
        offer(CMD_LOAD, 16'h8000);
        offer(CMD_LOAD, 16'h7FFF);
        offer(CMD_LOAD, 16'h0000);
        offer(CMD_LOAD, 16'hFFFF);
        // start of a third row, not yet readable
        offer(CMD_LOAD, 16'h00FF);
        // eight elements, last flag on the eighth, then nothing left
        read_out(9);
        // finish the third row after reading; limits move with it
        offer(CMD_LOAD, 16'hAAAA);
        offer(CMD_LOAD, 16'h0000);
        offer(CMD_LOAD, 16'h4000);
        offer(CMD_READ, 16'hFFFF);
        // new data set rewinds everything: read finds nothing
        offer(CMD_NEW, 16'h0000);
        offer(CMD_READ, 16'h5A5A);
        // sender pauses until every owed beat is back
        drain();

        // --- full store: loads past capacity are dropped, then a long
        // receiver hold-off while reads keep coming so the input stalls ---
        steady = 0;
        offer(CMD_NEW, SAMPLE_W'($urandom));
        for (int i = 0; i < STORE_DEPTH + 6; i++) begin
            if (i % NF == 0) pick_row_shape();
            offer(CMD_LOAD, gen_value((i / NF) % 4, i % NF));
        end
        steady = 1;
        send_beat(CMD_READ, SAMPLE_W'($urandom));
        // set on a rising edge, the receiver picks it up on the next falling one
        hold_request = HOLD_CYCLES;
        read_out(24);
        drain();

        // --- random part: mostly well-formed data sets with random content ---
        while (beats_taken < ITEM_TARGET) begin
            kind   = $urandom_range(0, 9);
            steady = ($urandom_range(0, 3) == 0);
            if (kind < 7) begin
                pick_row_shape();
                offer(CMD_NEW, SAMPLE_W'($urandom));
                case ($urandom_range(0, 2))
                    0:       load_rows($urandom_range(1, 10), $urandom_range(0, 3), 0);
                    1:       load_rows($urandom_range(1, 10), $urandom_range(0, 3), 10);
                    default: load_rows($urandom_range(1, 10), $urandom_range(0, 3), 30);
                endcase
                // a trailing partial row stays out of reach
                if ($urandom_range(0, 2) == 0)
                    repeat ($urandom_range(1, NF - 1)) offer(CMD_LOAD, SAMPLE_W'($urandom));
                read_out(board.unread() + $urandom_range(0, 2));
            end else begin
                noise_beats($urandom_range(5, 30));
            end
            if ($urandom_range(0, 3) == 0) drain();
        end

        // --- wind down ---
        drain();
        repeat (TAIL_CYCLES) @(negedge aclk);
        if (board.clean())
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
